// File: sv/jse_pkg.sv
// Shared types, character constants and a hex digit helper function for the JSON string escaper.
`default_nettype none

package jse_pkg;

   localparam int MaxBytes   = 6;
   localparam int CountWidth = $clog2(MaxBytes + 1);

   // Request codes carried in req_type.
   localparam logic [1:0] REQ_OPEN  = 2'd0;
   localparam logic [1:0] REQ_CHAR  = 2'd1;
   localparam logic [1:0] REQ_CLOSE = 2'd2;

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_SLASH     = 8'h2f;
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6e;
   localparam logic [7:0] CH_R         = 8'h72;

   localparam logic [31:0] LIMIT_1BYTE = 32'h0000_0080;
   localparam logic [31:0] LIMIT_2BYTE = 32'h0000_0800;
   localparam logic [31:0] LIMIT_3BYTE = 32'h0001_0000;
   localparam logic [31:0] LIMIT_4BYTE = 32'h0011_0000;

   localparam logic [7:0] LEAD_2BYTE = 8'hc0;
   localparam logic [7:0] LEAD_3BYTE = 8'he0;
   localparam logic [7:0] LEAD_4BYTE = 8'hf0;
   localparam logic [7:0] CONT_BYTE  = 8'h80;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] code_point;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_payload_type;

   // One encoded run: byte 0 goes out first.
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [CountWidth-1:0]    count;
   } run_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] d;
      d = {4'h0, v};
      if (v < 4'd10) begin
         hex_digit = d + CH_ZERO;
      end else begin
         hex_digit = d + 8'h57;
      end
   endfunction

endpackage

`default_nettype wire

// File: sv/jse_encode.sv
// Combinational encoder: one request into a run of up to six output bytes.
`default_nettype none

module jse_encode
   import jse_pkg::*;
(
   input  wire req_payload_type req,
   output run_type              run
);

   logic [31:0] cp;
   logic [7:0]  esc;
   logic        printable;

   assign cp        = req.code_point;
   assign printable = (cp[6:0] inside {[7'h20:7'h7e]});

   always_comb begin
      case (cp[6:0])
         7'h22:   esc = CH_QUOTE;
         7'h2f:   esc = CH_SLASH;
         7'h5c:   esc = CH_BACKSLASH;
         7'h08:   esc = CH_B;
         7'h09:   esc = CH_T;
         7'h0c:   esc = CH_F;
         7'h0a:   esc = CH_N;
         7'h0d:   esc = CH_R;
         default: esc = 8'h00;
      endcase
   end

   always_comb begin
      run.bytes = '0;
      run.count = '0;
      case (req.req_type)
         REQ_OPEN, REQ_CLOSE: begin
            run.bytes[0] = CH_QUOTE;
            run.count    = CountWidth'(1);
         end
         REQ_CHAR: begin
            if (cp < LIMIT_1BYTE) begin
               if (esc != 8'h00) begin
                  run.bytes[0] = CH_BACKSLASH;
                  run.bytes[1] = esc;
                  run.count    = CountWidth'(2);
               end else if (printable) begin
                  run.bytes[0] = {1'b0, cp[6:0]};
                  run.count    = CountWidth'(1);
               end else begin
                  // Remaining controls become a six-character unicode escape.
                  run.bytes[0] = CH_BACKSLASH;
                  run.bytes[1] = CH_U;
                  run.bytes[2] = CH_ZERO;
                  run.bytes[3] = CH_ZERO;
                  run.bytes[4] = hex_digit({1'b0, cp[6:4]});
                  run.bytes[5] = hex_digit(cp[3:0]);
                  run.count    = CountWidth'(6);
               end
            end else if (cp < LIMIT_2BYTE) begin
               run.bytes[0] = LEAD_2BYTE | {3'b000, cp[10:6]};
               run.bytes[1] = CONT_BYTE  | {2'b00, cp[5:0]};
               run.count    = CountWidth'(2);
            end else if (cp < LIMIT_3BYTE) begin
               run.bytes[0] = LEAD_3BYTE | {4'h0, cp[15:12]};
               run.bytes[1] = CONT_BYTE  | {2'b00, cp[11:6]};
               run.bytes[2] = CONT_BYTE  | {2'b00, cp[5:0]};
               run.count    = CountWidth'(3);
            end else if (cp < LIMIT_4BYTE) begin
               run.bytes[0] = LEAD_4BYTE | {5'b00000, cp[20:18]};
               run.bytes[1] = CONT_BYTE  | {2'b00, cp[17:12]};
               run.bytes[2] = CONT_BYTE  | {2'b00, cp[11:6]};
               run.bytes[3] = CONT_BYTE  | {2'b00, cp[5:0]};
               run.count    = CountWidth'(4);
            end
         end
         default: begin
            run.count = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: sv/jse_run_buf.sv
// Result register: holds one encoded run and shifts it out a byte per beat.
`default_nettype none

module jse_run_buf
   import jse_pkg::*;
(
   input  wire             clock,
   input  wire             reset,
   input  wire             load,
   input  wire run_type    load_run,
   output logic            can_load,
   output logic            rsp_valid,
   input  wire             rsp_ready,
   output rsp_payload_type rsp_data
);

   logic [MaxBytes-1:0][7:0] bytes_ff, bytes_in;
   logic [CountWidth-1:0]    remain_ff, remain_in;
   logic                     pop;

   assign rsp_valid            = (remain_ff != '0);
   assign pop                  = rsp_valid && rsp_ready;
   assign can_load             = (remain_ff == '0) || (pop && remain_ff == CountWidth'(1));
   assign rsp_data.out_byte    = bytes_ff[0];
   assign rsp_data.last_of_run = (remain_ff == CountWidth'(1));

   always_comb begin
      bytes_in  = bytes_ff;
      remain_in = remain_ff;
      if (load) begin
         bytes_in  = load_run.bytes;
         remain_in = load_run.count;
      end else if (pop) begin
         bytes_in  = {8'h00, bytes_ff[MaxBytes-1:1]};
         remain_in = remain_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
      end else begin
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

   a_remain_bound: assert property (@(posedge clock) disable iff (reset)
      remain_ff <= CountWidth'(MaxBytes))
      else $error("run buffer holds more bytes than a run can have");

   a_load_nonempty: assert property (@(posedge clock) disable iff (reset)
      load |-> (load_run.count != '0) && can_load)
      else $error("empty run or busy buffer at load");

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      load |=> remain_ff == $past(load_run.count))
      else $error("byte count not taken from the loaded run");

   a_pop_shift: assert property (@(posedge clock) disable iff (reset)
      (pop && !load && remain_ff > CountWidth'(1)) |=> rsp_data.out_byte == $past(bytes_ff[1]))
      else $error("next byte of the run not shifted forward");

endmodule

`default_nettype wire

// File: sv/json_string_escape_utf8.sv
// Top level of the JSON string escaper with UTF-8 encoding.
`default_nettype none

// Each request beat (open, character or close) is captured in an input register,
// encoded combinationally and moved into a result register that sends its bytes out one
// rsp beat each, with last_of_run set on the final byte. Open and close give a double
// quote; characters give escapes, plain ASCII or UTF-8 of 2 to 4 bytes. Request code 3
// and code points at or above 0x110000 give no bytes and leave the input register without
// a load. A new request is taken every cycle while each one yields a single byte and
// rsp_ready stays high; a longer run holds the result register until its last byte is
// taken, so the output port's one byte per cycle while rsp_ready is high sets throughput.
module json_string_escape_utf8
   import jse_pkg::*;
(
   input  wire             clock,
   input  wire             reset,
   input  wire             req_valid,
   output logic            req_ready,
   input  wire req_payload_type req_data,
   output logic            rsp_valid,
   input  wire             rsp_ready,
   output rsp_payload_type rsp_data
);

   logic            req_valid_ff, req_valid_in;
   req_payload_type req_data_ff, req_data_in;
   run_type         enc_run;
   logic            can_load;
   logic            advance;
   logic            load;

   jse_encode u_encode (
      .req (req_data_ff),
      .run (enc_run)
   );

   // Runs of zero bytes leave the input register without touching the result register.
   assign advance   = req_valid_ff && ((enc_run.count == '0) || can_load);
   assign load      = req_valid_ff && (enc_run.count != '0) && can_load;
   assign req_ready = !req_valid_ff || advance;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_data_in  = req_data_ff;
      if (req_ready) begin
         req_valid_in = req_valid;
         req_data_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
   end

   jse_run_buf u_run_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .load_run  (enc_run),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: verif/json_string_escape_utf8_test.sv
// Testbench for the JSON string escaper: directed and random token streams checked byte by byte.
`default_nettype none

module json_string_escape_utf8_test
   import jse_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] REQ_UNUSED   = 2'd3;
   localparam int         ITEM_TARGET  = 330;
   localparam int         CYCLE_LIMIT  = 200000;
   localparam int         DRAIN_CYCLES = 8;

   // Expected byte stream of the escaper and the checks against it.
   class escape_scoreboard;
      rsp_payload_type expected_bytes[$];
      int              mismatch_count = 0;

      function void push_byte(input logic [7:0] b);
         rsp_payload_type e;
         e.out_byte    = b;
         e.last_of_run = 1'b0;
         expected_bytes.push_back(e);
      endfunction

      function logic [7:0] hex_char(input logic [3:0] n);
         // Lower-case a to f above nine.
         return (n > 4'd9) ? 8'h61 + {4'h0, n} - 8'd10 : CH_ZERO + {4'h0, n};
      endfunction

      function void encode_ascii(input logic [6:0] c);
         logic [7:0] esc;
         case ({1'b0, c})
            CH_QUOTE:     esc = CH_QUOTE;
            CH_SLASH:     esc = CH_SLASH;
            CH_BACKSLASH: esc = CH_BACKSLASH;
            8'h08:        esc = CH_B;
            8'h09:        esc = CH_T;
            8'h0c:        esc = CH_F;
            8'h0a:        esc = CH_N;
            8'h0d:        esc = CH_R;
            default:      esc = 8'h00;
         endcase
         if (esc != 8'h00) begin
            push_byte(CH_BACKSLASH);
            push_byte(esc);
         end else if (c >= 7'h20 && c <= 7'h7e) begin
            push_byte({1'b0, c});
         end else begin
            push_byte(CH_BACKSLASH);
            push_byte(CH_U);
            push_byte(CH_ZERO);
            push_byte(CH_ZERO);
            push_byte(hex_char({1'b0, c[6:4]}));
            push_byte(hex_char(c[3:0]));
         end
      endfunction

      // Appends the bytes one accepted token must produce.
      function void note_request(input req_payload_type r);
         int         before_count;
         logic [31:0] cp;
         before_count = expected_bytes.size();
         cp = r.code_point;
         if (r.req_type == REQ_OPEN || r.req_type == REQ_CLOSE) begin
            push_byte(CH_QUOTE);
         end else if (r.req_type == REQ_CHAR) begin
            if (cp < LIMIT_1BYTE) begin
               encode_ascii(cp[6:0]);
            end else if (cp < LIMIT_2BYTE) begin
               push_byte(LEAD_2BYTE | {3'b0, cp[10:6]});
               push_byte(CONT_BYTE | {2'b0, cp[5:0]});
            end else if (cp < LIMIT_3BYTE) begin
               push_byte(LEAD_3BYTE | {4'b0, cp[15:12]});
               push_byte(CONT_BYTE | {2'b0, cp[11:6]});
               push_byte(CONT_BYTE | {2'b0, cp[5:0]});
            end else if (cp < LIMIT_4BYTE) begin
               push_byte(LEAD_4BYTE | {5'b0, cp[20:18]});
               push_byte(CONT_BYTE | {2'b0, cp[17:12]});
               push_byte(CONT_BYTE | {2'b0, cp[11:6]});
               push_byte(CONT_BYTE | {2'b0, cp[5:0]});
            end
         end
         if (expected_bytes.size() > before_count) begin
            expected_bytes[expected_bytes.size() - 1].last_of_run = 1'b1;
         end
      endfunction

      task report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
         mismatch_count++;
         $display("tb: mismatch at %0t: %s got 0x%02h expected 0x%02h", $time, what, got, want);
      endtask

      task check_byte(input rsp_payload_type got);
         rsp_payload_type want;
         if (expected_bytes.size() == 0) begin
            report_mismatch("unexpected beat, out_byte", got.out_byte, 8'h00);
         end else begin
            want = expected_bytes.pop_front();
            if (got.out_byte != want.out_byte) begin
               report_mismatch("out_byte", got.out_byte, want.out_byte);
            end
            if (got.last_of_run != want.last_of_run) begin
               report_mismatch("last_of_run", {7'b0, got.last_of_run},
                               {7'b0, want.last_of_run});
            end
         end
      endtask

      function int pending();
         return expected_bytes.size();
      endfunction
   endclass

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;

   escape_scoreboard sb;
   int               cycle_count   = 0;
   int               burst_left    = 0;
   int               useful_sent   = 0;

   json_string_escape_utf8 u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10ns clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver: checks each beat and stalls on a pattern chosen by bits 8:7 of the cycle count.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_byte(rsp_data);
      end
      case (cycle_count[8:7])
         2'd0:    rsp_ready <= 1'b1;
         2'd1:    rsp_ready <= ($urandom_range(0, 3) != 0);
         2'd2:    rsp_ready <= (cycle_count[2:0] == 3'd0);
         default: rsp_ready <= ($urandom_range(0, 1) == 1);
      endcase
   end

   function automatic req_payload_type make_req(input logic [1:0] t, input logic [31:0] cp);
      req_payload_type r;
      r.req_type   = t;
      r.code_point = cp;
      return r;
   endfunction

   function automatic logic [31:0] random_code_point();
      int          sel;
      logic [31:0] cp;
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
         cp = $urandom_range(32'h20, 32'h7e);
      end else if (sel < 45) begin
         case ($urandom_range(0, 7))
            0:       cp = {24'h0, CH_QUOTE};
            1:       cp = {24'h0, CH_SLASH};
            2:       cp = {24'h0, CH_BACKSLASH};
            3:       cp = 32'h08;
            4:       cp = 32'h09;
            5:       cp = 32'h0c;
            6:       cp = 32'h0a;
            default: cp = 32'h0d;
         endcase
      end else if (sel < 53) begin
         cp = ($urandom_range(0, 8) == 0) ? 32'h7f : $urandom_range(0, 32'h1f);
      end else if (sel < 66) begin
         cp = $urandom_range(LIMIT_1BYTE, LIMIT_2BYTE - 1);
      end else if (sel < 78) begin
         cp = $urandom_range(LIMIT_2BYTE, LIMIT_3BYTE - 1);
      end else if (sel < 83) begin
         cp = $urandom_range(32'hd800, 32'hdfff);
      end else if (sel < 96) begin
         cp = $urandom_range(LIMIT_3BYTE, LIMIT_4BYTE - 1);
      end else begin
         cp = $urandom();
         if (cp < LIMIT_4BYTE) begin
            cp[31] = 1'b1;
         end
      end
      return cp;
   endfunction

   // Holds one token on the request port until it is taken, then maybe idles.
   task automatic send_request(input req_payload_type r);
      int gap;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
      if (r.req_type != REQ_UNUSED &&
          !(r.req_type == REQ_CHAR && r.code_point >= LIMIT_4BYTE)) begin
         useful_sent++;
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(30, 60);
            gap = 0;
         end else begin
            burst_left = $urandom_range(0, 9);
            gap = $urandom_range(0, 6);
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int  pick;
      int  nchars;
      bit  paused_midway;
      sb = new();
      paused_midway = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: quotes, every escape, control and UTF-8 boundary, ignored tokens.
      send_request(make_req(REQ_OPEN, 32'hffff_ffff));
      send_request(make_req(REQ_CHAR, 32'h00));
      send_request(make_req(REQ_CHAR, 32'h08));
      send_request(make_req(REQ_CHAR, 32'h09));
      send_request(make_req(REQ_CHAR, 32'h0a));
      send_request(make_req(REQ_CHAR, 32'h0c));
      send_request(make_req(REQ_CHAR, 32'h0d));
      send_request(make_req(REQ_CHAR, 32'h1f));
      send_request(make_req(REQ_CHAR, 32'h20));
      send_request(make_req(REQ_CHAR, CH_QUOTE));
      send_request(make_req(REQ_CHAR, CH_SLASH));
      send_request(make_req(REQ_CHAR, CH_BACKSLASH));
      send_request(make_req(REQ_CHAR, 32'h7e));
      send_request(make_req(REQ_CHAR, 32'h7f));
      send_request(make_req(REQ_CHAR, 32'h80));
      send_request(make_req(REQ_CHAR, 32'h7ff));
      send_request(make_req(REQ_CHAR, 32'h800));
      send_request(make_req(REQ_CHAR, 32'hd800));
      send_request(make_req(REQ_CHAR, 32'hdfff));
      send_request(make_req(REQ_CHAR, 32'hffff));
      send_request(make_req(REQ_CHAR, 32'h1_0000));
      send_request(make_req(REQ_CHAR, 32'h10_ffff));
      send_request(make_req(REQ_CHAR, 32'h11_0000));
      send_request(make_req(REQ_CHAR, 32'hffff_ffff));
      send_request(make_req(REQ_UNUSED, 32'h0000_0041));
      send_request(make_req(REQ_CLOSE, 32'h0000_0000));
      wait_drained();

      // Random: mostly whole strings, some broken strings and stray tokens.
      useful_sent = 0;
      while (useful_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            send_request(make_req(REQ_OPEN, $urandom()));
            nchars = $urandom_range(1, 8);
            repeat (nchars) send_request(make_req(REQ_CHAR, random_code_point()));
            if ($urandom_range(0, 9) != 0) begin
               send_request(make_req(REQ_CLOSE, $urandom()));
            end
         end else begin
            case ($urandom_range(0, 3))
               0:       send_request(make_req(REQ_UNUSED, $urandom()));
               1:       send_request(make_req(REQ_CHAR, $urandom() | 32'h0100_0000));
               2:       send_request(make_req(REQ_CLOSE, $urandom()));
               default: send_request(make_req(REQ_CHAR, random_code_point()));
            endcase
         end
         if (!paused_midway && useful_sent >= ITEM_TARGET / 2) begin
            paused_midway = 1'b1;
            wait_drained();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
